>>> rtl/core/infix_to_postfix_converter_macros.svh
// Assertion macros used by the port checker of the converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2P_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2P_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/i2p_pkg.sv
// Types, character codes and helper functions of the infix to postfix converter.
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Kind of an input character as seen by the stack engine.
  typedef enum logic [2:0] {
    CLS_OPND,
    CLS_OPER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_IGNORE
  } cls_e;

  // States of the stack engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_OPER,
    ST_PUSH,
    ST_CLOSE,
    ST_FLUSH
  } state_e;

  // One classified character waiting in the queue.
  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic       fin;
  } item_t;

  // One postfix result.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_end;
    logic       expr_done;
    logic       overflow;
  } result_t;

  // Binding weight of an operator; zero for anything else.
  function automatic logic [1:0] op_weight(input logic [7:0] c);
    logic [1:0] w;
    w = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      w = 2'd1;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      w = 2'd2;
    end else if (c == CH_DOLLAR) begin
      w = 2'd3;
    end
    return w;
  endfunction

  // True when the stacked operator leaves before the incoming one is pushed.
  function automatic logic pops_before(input logic [7:0] top, input logic [7:0] inc);
    logic [1:0] wt;
    logic [1:0] wi;
    wt = op_weight(top);
    wi = op_weight(inc);
    if (wt == wi) begin
      return top != CH_DOLLAR;
    end
    return wt > wi;
  endfunction

  // Sorts a character into operand, operator, brackets or dropped.
  function automatic cls_e classify(input logic [7:0] c);
    cls_e k;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h41 && c <= 8'h5A)) begin
      k = CLS_OPND;
    end else if (op_weight(c) != 2'd0) begin
      k = CLS_OPER;
    end else if (c == CH_LPAREN) begin
      k = CLS_OPEN;
    end else if (c == CH_RPAREN) begin
      k = CLS_CLOSE;
    end else begin
      k = CLS_IGNORE;
    end
    return k;
  endfunction

endpackage

>>> rtl/core/infix_to_postfix_converter.sv
// Each emitted character waits in a holding register until the next one emitted, or the end of
// its run, moves it into the output register. The stack engine takes a new character only in
// its idle state, after it has finished the last one; one stack entry leaves per cycle while it
// pops, unless the holding and output registers are both full and the receiver stalls.
// Reset: asynchronous, active low; clears the stack count, overflow flag and queue.
// Stack contents are not cleared and are undefined until pushed; no clearing pass.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // is_final
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [2:0] m_axis_tuser,   // [0] has_char, [1] expr_done, [2] overflow
  output logic       m_axis_tlast    // run_end
);
  import i2p_pkg::*;

  item_t   item;
  logic    item_valid, item_ready;
  result_t res;

  // Classification and queue.
  i2p_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_char_i    (s_axis_tdata),
    .is_final_i   (s_axis_tlast),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Stack engine.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  // Result packing onto the master stream.
  assign m_axis_tdata = res.ch;
  assign m_axis_tuser = {res.overflow, res.expr_done, res.has_char};
  assign m_axis_tlast = res.run_end;

endmodule

>>> rtl/core/i2p_front.sv
// Front end: classifies incoming characters and queues them for the stack engine.
module i2p_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     in_char_i,
  input  logic           is_final_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output i2p_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);
  import i2p_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  item_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           push, pop;
  item_t          new_item;

  // Classify the character on its way in.
  always_comb begin
    new_item.cls = classify(in_char_i);
    new_item.ch  = in_char_i;
    new_item.fin = is_final_i;
  end

  assign in_ready_o   = fill_q != FW'(QUEUE_DEPTH);
  assign item_valid_o = fill_q != '0;
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue entries hold payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> rtl/core/i2p_back.sv
// Back end: operator stack engine with a one-result holding stage and output register.
module i2p_back #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i2p_pkg::item_t   item_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  output i2p_pkg::result_t res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);
  import i2p_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  state_e         state_q, state_d, eff_state;
  item_t          cur_q;
  item_t          cur;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  rd_idx;
  logic           ovf_q, ovf_d;
  logic [7:0]     stack_mem [STACK_DEPTH];
  logic [7:0]     top_q;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           wr_en;
  logic [7:0]     wr_data;
  logic           pend_vld_q, pend_vld_d;
  logic [7:0]     pend_char_q, pend_char_d;
  result_t        out_q, out_d;
  logic           out_vld_q, out_vld_d;
  logic           ofree, emit_ok, stack_ne, stack_full, top_open;
  logic           pop_oper, pop_close, flush_pop;
  logic           emit, close_run;
  logic [7:0]     emit_char;

  // The idle state works directly on the queue head.
  assign item_ready_o = state_q == ST_IDLE;
  assign cur          = (state_q == ST_IDLE) ? item_i : cur_q;

  always_comb begin
    eff_state = state_q;
    if (state_q == ST_IDLE) begin
      if (!item_valid_i) begin
        eff_state = ST_IDLE;
      end else begin
        unique case (item_i.cls)
          CLS_OPND:  eff_state = ST_OPND;
          CLS_OPER:  eff_state = ST_OPER;
          CLS_OPEN:  eff_state = ST_PUSH;
          CLS_CLOSE: eff_state = ST_CLOSE;
          default:   eff_state = ST_FLUSH;
        endcase
      end
    end
  end

  // Stack and output conditions.
  assign ofree      = !out_vld_q || res_ready_i;
  assign emit_ok    = !pend_vld_q || ofree;
  assign stack_ne   = cnt_q != '0;
  assign stack_full = cnt_q == CW'(STACK_DEPTH);
  assign top_open   = top_q == CH_LPAREN;
  assign pop_oper   = stack_ne && !top_open && pops_before(top_q, cur.ch);
  assign pop_close  = stack_ne && !top_open;
  assign flush_pop  = cur.fin && stack_ne;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (eff_state)
      ST_IDLE:  state_d = ST_IDLE;
      ST_OPND:  state_d = emit_ok ? ST_FLUSH : ST_OPND;
      ST_OPER:  state_d = pop_oper ? ST_OPER : ST_FLUSH;
      ST_PUSH:  state_d = ST_FLUSH;
      ST_CLOSE: state_d = pop_close ? ST_CLOSE : ST_FLUSH;
      ST_FLUSH: state_d = (!flush_pop && ofree) ? ST_IDLE : ST_FLUSH;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Stack actions for the current state.
  always_comb begin
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    wr_en     = 1'b0;
    wr_data   = cur.ch;
    emit      = 1'b0;
    emit_char = top_q;
    close_run = 1'b0;
    unique case (eff_state)
      ST_IDLE: begin
      end
      ST_OPND: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_char = cur.ch;
        end
      end
      ST_OPER, ST_PUSH: begin
        if (eff_state == ST_OPER && pop_oper) begin
          if (emit_ok) begin
            emit  = 1'b1;
            cnt_d = cnt_q - CW'(1);
          end
        end else if (stack_full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_CLOSE: begin
        if (pop_close) begin
          if (emit_ok) begin
            emit  = 1'b1;
            cnt_d = cnt_q - CW'(1);
          end
        end else if (stack_ne) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_FLUSH: begin
        if (flush_pop) begin
          if (emit_ok) begin
            emit  = 1'b1;
            cnt_d = cnt_q - CW'(1);
          end
        end else if (ofree) begin
          close_run = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // A new character displaces the held one into the output register; the
  // held one is only marked as the end of the run once the item is finished.
  always_comb begin
    out_d       = out_q;
    out_vld_d   = out_vld_q && !res_ready_i;
    pend_vld_d  = pend_vld_q;
    pend_char_d = pend_char_q;
    if (emit) begin
      if (pend_vld_q) begin
        out_vld_d       = 1'b1;
        out_d.ch        = pend_char_q;
        out_d.has_char  = 1'b1;
        out_d.run_end   = 1'b0;
        out_d.expr_done = 1'b0;
        out_d.overflow  = ovf_q;
      end
      pend_vld_d  = 1'b1;
      pend_char_d = emit_char;
    end else if (close_run) begin
      out_vld_d       = 1'b1;
      out_d.ch        = pend_vld_q ? pend_char_q : CH_NUL;
      out_d.has_char  = pend_vld_q;
      out_d.run_end   = 1'b1;
      out_d.expr_done = cur.fin;
      out_d.overflow  = ovf_q;
      pend_vld_d      = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      cur_q <= item_i;
    end
    pend_char_q <= pend_char_d;
    out_q       <= out_d;
  end

  // Operator stack memory; the read port always tracks the next top entry.
  assign rd_idx  = cnt_d - CW'(1);
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    top_q <= (wr_en && wr_addr == rd_addr) ? wr_data : stack_mem[rd_addr];
  end

  assign res_o       = out_q;
  assign res_valid_o = out_vld_q;

endmodule

>>> rtl/core/i2p_checker.sv
// Port-level checks on the converter's result stream, bound to the top level.
`include "infix_to_postfix_converter_macros.svh"

module i2p_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result keeps its contents.
  `I2P_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // An empty marker carries a zero character and closes its run.
  `I2P_ASSERT_NOW(a_marker, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'h00 && m_axis_tlast, "empty marker malformed")

  // The end of an expression is always the end of a run.
  `I2P_ASSERT_NOW(a_done_end, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "expression end without run end")

  // Once overflow shows, every later result shows it too.
  `I2P_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2], !m_axis_tvalid || m_axis_tuser[2], "overflow flag cleared")

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/infix_to_postfix_converter_checker.sv
// Checker of the infix to postfix converter: predicts postfix results and compares transfers.
module infix_to_postfix_converter_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_char
  input  logic       s_axis_tlast_i,   // is_final
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,   // [7:0] out_char
  input  logic [2:0] m_axis_tuser_i,   // [0] has_char, [1] expr_done, [2] overflow
  input  logic       m_axis_tlast_i,   // run_end
  output int         errors_o,
  output int         pending_o
);
  import i2p_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;

  // Predicted operator stack, its fill level and the sticky overflow flag.
  logic [7:0]  held_ops [DEPTH];
  int unsigned held_cnt;
  logic        ovf_sticky;

  // Postfix results still owed by the converter, oldest first.
  result_t expected_postfix_q[$];

  // Binding strength of an operator character; zero for anything else.
  function automatic int unsigned bind_weight(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS: return 1;
      CH_STAR, CH_SLASH: return 2;
      CH_DOLLAR:         return 3;
      default:           return 0;
    endcase
  endfunction

  function automatic bit is_operand_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // A stacked operator leaves first when it binds tighter, or equally and is left-associative.
  function automatic bit yields_to(input logic [7:0] top, input logic [7:0] inc);
    if (bind_weight(top) == bind_weight(inc)) begin
      return top != CH_DOLLAR;
    end
    return bind_weight(top) > bind_weight(inc);
  endfunction

  function automatic result_t char_result(input logic [7:0] c);
    result_t r;
    r = '0;
    r.ch = c;
    r.has_char = 1'b1;
    return r;
  endfunction

  // A push onto a full stack is lost and marks the overflow.
  task automatic push_held(input logic [7:0] c);
    if (held_cnt >= DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      held_ops[held_cnt] = c;
      held_cnt++;
    end
  endtask

  // Works out every result that one accepted character causes.
  task automatic predict_char(input logic [7:0] ch, input logic fin);
    result_t run_q[$];
    int unsigned k;
    if (is_operand_char(ch)) begin
      run_q.push_back(char_result(ch));
    end else if (bind_weight(ch) != 0) begin
      while (held_cnt > 0 && held_ops[held_cnt-1] != CH_LPAREN &&
             yields_to(held_ops[held_cnt-1], ch)) begin
        run_q.push_back(char_result(held_ops[held_cnt-1]));
        held_cnt--;
      end
      push_held(ch);
    end else if (ch == CH_LPAREN) begin
      push_held(ch);
    end else if (ch == CH_RPAREN) begin
      while (held_cnt > 0 && held_ops[held_cnt-1] != CH_LPAREN) begin
        run_q.push_back(char_result(held_ops[held_cnt-1]));
        held_cnt--;
      end
      if (held_cnt > 0) begin
        held_cnt--;
      end
    end

    // The last character of an expression empties the whole stack.
    if (fin) begin
      while (held_cnt > 0) begin
        run_q.push_back(char_result(held_ops[held_cnt-1]));
        held_cnt--;
      end
    end

    // A character that emits nothing still yields an empty marker.
    if (run_q.size() == 0) begin
      run_q.push_back('0);
    end
    for (k = 0; k < run_q.size(); k++) begin
      run_q[k].overflow = ovf_sticky;
    end
    run_q[run_q.size()-1].run_end = 1'b1;
    run_q[run_q.size()-1].expr_done = fin;
    foreach (run_q[i]) begin
      expected_postfix_q.push_back(run_q[i]);
    end
  endtask

  // Input transfers feed the prediction; output transfers are compared in order.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      held_cnt = 0;
      ovf_sticky = 1'b0;
      expected_postfix_q.delete();
      errors_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_char(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.ch = m_axis_tdata_i;
        got.has_char = m_axis_tuser_i[0];
        got.expr_done = m_axis_tuser_i[1];
        got.overflow = m_axis_tuser_i[2];
        got.run_end = m_axis_tlast_i;
        if (expected_postfix_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result: expected none, got ch=%h has=%b end=%b done=%b ovf=%b",
                   $time, got.ch, got.has_char, got.run_end, got.expr_done, got.overflow);
        end else begin
          want = expected_postfix_q.pop_front();
          if (got.ch !== want.ch || got.has_char !== want.has_char ||
              got.run_end !== want.run_end || got.expr_done !== want.expr_done ||
              got.overflow !== want.overflow) begin
            errors_o++;
            $display("%0t: mismatch: expected ch=%h has=%b end=%b done=%b ovf=%b", $time,
                     want.ch, want.has_char, want.run_end, want.expr_done, want.overflow);
            $display("%0t:           got ch=%h has=%b end=%b done=%b ovf=%b", $time,
                     got.ch, got.has_char, got.run_end, got.expr_done, got.overflow);
          end
        end
      end
    end
    pending_o = expected_postfix_q.size();
  end

endmodule

>>> tb/infix_to_postfix_converter_tb.sv
// Testbench top of the infix to postfix converter: stimulus, flow control and verdict.
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 57;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int          mismatches;
  int          outstanding;

  // One character of an expression together with its final mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } sym_t;

  sym_t burst_q[$];

  infix_to_postfix_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  infix_to_postfix_converter_checker postfix_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .errors_o        (mismatches),
    .pending_o       (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Receiver flow control: a requested hold-off first, random stalls otherwise.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // The run is stuck when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one character and returns at the edge where it was transferred.
  task automatic send_sym(input logic [7:0] ch, input logic fin);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= fin;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end
  endtask

  task automatic push_sym(input logic [7:0] ch, input logic fin);
    sym_t s;
    s.ch = ch;
    s.fin = fin;
    burst_q.push_back(s);
  endtask

  task automatic play_burst();
    foreach (burst_q[i]) begin
      send_sym(burst_q[i].ch, burst_q[i].fin);
    end
    burst_q.delete();
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(2))
      0:       return 8'("0" + $urandom_range(9));
      1:       return 8'("a" + $urandom_range(25));
      default: return 8'("A" + $urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_DOLLAR;
    endcase
  endfunction

  // Well-formed expression with random operands, operators, nesting and some noise.
  task automatic build_expression(output int unsigned meaningful);
    int unsigned depth;
    int unsigned operands;
    int unsigned target;
    bit          need_operand;
    meaningful = 0;
    depth = 0;
    operands = 0;
    target = $urandom_range(1, 8);
    need_operand = 1'b1;
    while (need_operand || operands < target) begin
      if ($urandom_range(99) < 8) begin
        push_sym(8'($urandom_range(255)), 1'b0);
      end
      if (need_operand) begin
        if (depth < 5 && $urandom_range(99) < 25) begin
          push_sym(CH_LPAREN, 1'b0);
          depth++;
        end else begin
          push_sym(pick_operand(), 1'b0);
          operands++;
          need_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(99) < 30) begin
        push_sym(CH_RPAREN, 1'b0);
        depth--;
      end else begin
        push_sym(pick_operator(), 1'b0);
        need_operand = 1'b1;
      end
      meaningful++;
    end
    // Usually close the open brackets; the rest are left for the flush.
    while (depth > 0 && $urandom_range(99) < 85) begin
      push_sym(CH_RPAREN, 1'b0);
      depth--;
      meaningful++;
    end
    if ($urandom_range(99) < 15) begin
      push_sym(" ", 1'b1);
    end else begin
      burst_q[burst_q.size()-1].fin = 1'b1;
    end
  endtask

  // Broken sequence: tokens in any order, final marks anywhere or missing.
  task automatic build_scramble(output int unsigned meaningful);
    int unsigned n;
    logic [7:0]  c;
    n = $urandom_range(3, 10);
    meaningful = n;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0:       c = pick_operand();
        1:       c = pick_operator();
        2:       c = CH_LPAREN;
        3:       c = CH_RPAREN;
        default: c = 8'($urandom_range(255));
      endcase
      push_sym(c, (i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(99) < 10));
    end
  endtask

  // One stretch of random traffic at the given idle rates.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input bit with_hold);
    int unsigned sent;
    int unsigned got;
    bit          held;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    held = 1'b0;
    while (sent < ITEMS_PER_PHASE) begin
      if (with_hold && !held && sent > 20) begin
        hold_left = HOLD_CYCLES;
        held = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        build_expression(got);
      end else begin
        build_scramble(got);
      end
      play_burst();
      sent += got;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 11;
    snk_idle_pct = 52;

    // Directed: field extremes, empty-stack close, every operator, associativity,
    // dropped characters, close without an open, and an open left for the flush.
    push_sym(8'h00, 1'b0);
    push_sym(8'hFF, 1'b1);
    push_sym(CH_RPAREN, 1'b0);
    push_sym("A", 1'b0);
    push_sym(CH_PLUS, 1'b0);
    push_sym("z", 1'b0);
    push_sym(CH_STAR, 1'b0);
    push_sym("0", 1'b0);
    push_sym(CH_DOLLAR, 1'b0);
    push_sym("9", 1'b0);
    push_sym(CH_DOLLAR, 1'b0);
    push_sym("Z", 1'b0);
    push_sym(CH_MINUS, 1'b0);
    push_sym(CH_LPAREN, 1'b0);
    push_sym("b", 1'b0);
    push_sym(CH_SLASH, 1'b0);
    push_sym(" ", 1'b0);
    push_sym("Y", 1'b0);
    push_sym(",", 1'b0);
    push_sym(CH_RPAREN, 1'b0);
    push_sym("[", 1'b0);
    push_sym(CH_RPAREN, 1'b0);
    push_sym(CH_LPAREN, 1'b0);
    push_sym("a", 1'b0);
    push_sym(CH_PLUS, 1'b1);
    play_burst();

    run_phase(11, 52, 1'b0);
    run_phase(52, 11, 1'b0);
    run_phase(0, 0, 1'b1);

    // Fill the stack with right-associative operators past its depth, then pop
    // it all at once while the receiver holds off.
    hold_left = HOLD_CYCLES;
    for (int unsigned i = 0; i <= STACK_DEPTH_DEF; i++) begin
      push_sym(CH_DOLLAR, 1'b0);
    end
    push_sym(CH_PLUS, 1'b1);
    play_burst();
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
